// ===== rtl/poab_pkg.sv =====
// Shared types and constants for the positioned overlay alpha blend mixer.
package poab_pkg;

    localparam int OVERLAY_MAX_SIDE = 128;
    localparam int OVL_IDX_W        = $clog2(OVERLAY_MAX_SIDE);
    localparam int OVL_ADDR_W       = 2 * OVL_IDX_W;
    localparam int OVL_DEPTH        = OVERLAY_MAX_SIDE * OVERLAY_MAX_SIDE;

    localparam int POS_W      = 12;
    localparam int COORD_W    = 13;
    localparam int DELTA_W    = 14;
    localparam int CHAN_W     = 8;
    localparam int SIDE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int WORD_W     = 4 * CHAN_W;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_BASE = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_WINDOW_LEFT   = 3'd2,
        CFG_WINDOW_TOP    = 3'd3,
        CFG_WINDOW_WIDTH  = 3'd4,
        CFG_WINDOW_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  pos_col;
        logic [POS_W-1:0]  pos_row;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] alpha;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_alpha;
        logic              covered;
    } t_out_beat;

endpackage

// ===== rtl/poab_mix.sv =====
// One color channel of the overlay blend: multiply, round and select.
module poab_mix
    import poab_pkg::*;
(
    input  logic [CHAN_W-1:0] i_ovl,
    input  logic [CHAN_W-1:0] i_base,
    input  logic [CHAN_W-1:0] i_alpha,
    output logic [CHAN_W-1:0] o_mix
);

    localparam logic [CHAN_W-1:0] ALPHA_NONE = '0;
    localparam logic [CHAN_W-1:0] ALPHA_FULL = '1;
    localparam int                SUM_W      = 2 * CHAN_W + 1;

    logic [SUM_W-1:0] sum;

    always_comb begin
        sum = SUM_W'(i_ovl) * SUM_W'(i_alpha)
            + SUM_W'(i_base) * SUM_W'(ALPHA_FULL - i_alpha)
            + SUM_W'(1 << (CHAN_W - 1));
        if (i_alpha == ALPHA_NONE) begin
            o_mix = i_base;
        end else if (i_alpha == ALPHA_FULL) begin
            o_mix = i_ovl;
        end else begin
            o_mix = sum[2*CHAN_W-1:CHAN_W];
        end
    end

endmodule

// ===== rtl/positioned_overlay_alpha_blend.sv =====
// Top level of the positioned overlay alpha blend mixer: pipeline, overlay store, config.
// A base pixel passes the stage 1, 2 and 3 registers in order; loads yield no result.
// Throughput: one beat per cycle while not stalled, loads and base pixels mixed freely.
// The single-port overlay store is accessed once per beat in stage 2, so loads and reads
// stay in order and a read always sees every earlier load.
// Reset clears valid bits and sets config defaults; the overlay store is not cleared.
module positioned_overlay_alpha_blend
    import poab_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    // config writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [DELTA_W-1:0] SIDE_D = DELTA_W'(OVERLAY_MAX_SIDE);

    // ------------------------------------------------------------------
    // Config registers. Write them only while the pipeline is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_frame_width;
    logic [COORD_W-1:0] r_frame_height;
    logic [COORD_W-1:0] r_window_left;
    logic [COORD_W-1:0] r_window_top;
    logic [SIDE_W-1:0]  r_window_width;
    logic [SIDE_W-1:0]  r_window_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= COORD_W'(1920);
            r_frame_height  <= COORD_W'(1080);
            r_window_left   <= '0;
            r_window_top    <= '0;
            r_window_width  <= '0;
            r_window_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                CFG_WINDOW_LEFT:   r_window_left   <= i_cfg_data;
                CFG_WINDOW_TOP:    r_window_top    <= i_cfg_data;
                CFG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data[SIDE_W-1:0];
                CFG_WINDOW_HEIGHT: r_window_height <= i_cfg_data[SIDE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Each stage moves when the stage after it is empty
    // or moving, so bubbles collapse and a stall backs up one stage at a time.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3        = !r_v3 || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;

    // ------------------------------------------------------------------
    // Stage 1 entry: offsets from the window origin and the frame clip.
    // ------------------------------------------------------------------
    t_in_beat                   r_s1_beat;
    logic signed [DELTA_W-1:0]  r_s1_dx;
    logic signed [DELTA_W-1:0]  r_s1_dy;
    logic                       r_s1_in_frame;
    logic signed [DELTA_W-1:0]  n_s1_dx;
    logic signed [DELTA_W-1:0]  n_s1_dy;
    logic                       n_s1_in_frame;

    always_comb begin
        n_s1_dx = $signed({2'b00, i_in_beat.pos_col})
                - $signed({r_window_left[COORD_W-1], r_window_left});
        n_s1_dy = $signed({2'b00, i_in_beat.pos_row})
                - $signed({r_window_top[COORD_W-1], r_window_top});
        // a zero frame size fails these compares and covers nothing
        n_s1_in_frame = ({1'b0, i_in_beat.pos_col} < r_frame_width)
                     && ({1'b0, i_in_beat.pos_row} < r_frame_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_beat     <= i_in_beat;
            r_s1_dx       <= n_s1_dx;
            r_s1_dy       <= n_s1_dy;
            r_s1_in_frame <= n_s1_in_frame;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: window test and store address. Oversized window sides
    // saturate to the store side.
    // ------------------------------------------------------------------
    logic [DELTA_W-1:0]    ww_c;
    logic [DELTA_W-1:0]    wh_c;
    logic                  s1_cover;
    logic                  s1_is_load;
    logic                  s1_load_ok;
    logic                  mem_we;
    logic [OVL_ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0]     mem_wdata;

    always_comb begin
        ww_c = {{(DELTA_W-SIDE_W){1'b0}}, r_window_width};
        wh_c = {{(DELTA_W-SIDE_W){1'b0}}, r_window_height};
        if (ww_c > SIDE_D) begin
            ww_c = SIDE_D;
        end
        if (wh_c > SIDE_D) begin
            wh_c = SIDE_D;
        end

        s1_cover = r_s1_in_frame
                && (ww_c != '0) && (wh_c != '0)
                && (r_s1_dx >= 0) && (r_s1_dx < $signed(ww_c))
                && (r_s1_dy >= 0) && (r_s1_dy < $signed(wh_c));

        s1_is_load = (r_s1_beat.kind == KIND_LOAD);
        // drop loads that fall outside the store
        s1_load_ok = ({1'b0, r_s1_beat.pos_col} < (POS_W+1)'(OVERLAY_MAX_SIDE))
                  && ({1'b0, r_s1_beat.pos_row} < (POS_W+1)'(OVERLAY_MAX_SIDE));

        mem_we = en2 && r_v1 && s1_is_load && s1_load_ok;

        if (s1_is_load) begin
            mem_addr = {r_s1_beat.pos_row[OVL_IDX_W-1:0], r_s1_beat.pos_col[OVL_IDX_W-1:0]};
        end else begin
            mem_addr = {r_s1_dy[OVL_IDX_W-1:0], r_s1_dx[OVL_IDX_W-1:0]};
        end

        mem_wdata = {r_s1_beat.alpha, r_s1_beat.red, r_s1_beat.green, r_s1_beat.blue};
    end

    // ------------------------------------------------------------------
    // Stage 2 entry: overlay store access. One access per beat, in order.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_ovl_mem [OVL_DEPTH];
    logic [WORD_W-1:0] r_rd_word;
    t_in_beat          r_s2_beat;
    logic              r_s2_cover;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            if (mem_we) begin
                r_ovl_mem[mem_addr] <= mem_wdata;
            end
            r_rd_word <= r_ovl_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            // loads end here; only base pixels travel on
            r_v2 <= r_v1 && !s1_is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_beat  <= r_s1_beat;
            r_s2_cover <= s1_cover;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: blend each color channel with the stored overlay pixel.
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] mix_b, mix_g, mix_r;
    logic [CHAN_W-1:0] ovl_a;
    t_out_beat         n_out_beat;

    assign ovl_a = r_rd_word[4*CHAN_W-1:3*CHAN_W];

    poab_mix u_mix_b (
        .i_ovl   (r_rd_word[CHAN_W-1:0]),
        .i_base  (r_s2_beat.blue),
        .i_alpha (ovl_a),
        .o_mix   (mix_b)
    );

    poab_mix u_mix_g (
        .i_ovl   (r_rd_word[2*CHAN_W-1:CHAN_W]),
        .i_base  (r_s2_beat.green),
        .i_alpha (ovl_a),
        .o_mix   (mix_g)
    );

    poab_mix u_mix_r (
        .i_ovl   (r_rd_word[3*CHAN_W-1:2*CHAN_W]),
        .i_base  (r_s2_beat.red),
        .i_alpha (ovl_a),
        .o_mix   (mix_r)
    );

    always_comb begin
        n_out_beat.out_alpha = r_s2_beat.alpha;
        n_out_beat.covered   = r_s2_cover;
        if (r_s2_cover) begin
            n_out_beat.out_blue  = mix_b;
            n_out_beat.out_green = mix_g;
            n_out_beat.out_red   = mix_r;
        end else begin
            // outside the clipped window: pass the base pixel through
            n_out_beat.out_blue  = r_s2_beat.blue;
            n_out_beat.out_green = r_s2_beat.green;
            n_out_beat.out_red   = r_s2_beat.red;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: output register, held while the consumer stalls.
    // ------------------------------------------------------------------
    t_out_beat r_s3_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_beat  = r_s3_beat;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while a pipeline stage is empty");

    a_no_load_past_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2_beat.kind == KIND_BASE))
        else $error("load beat travelled past the store stage");

    a_write_only_for_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_v1 && s1_is_load))
        else $error("overlay store written without a load beat");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en2) |=> (r_v2 && $stable(r_s2_beat) && $stable(r_rd_word)))
        else $error("stage 2 lost or changed its beat while held");

endmodule

// ===== tb/positioned_overlay_alpha_blend_tb.sv =====
// Self-checking testbench for the positioned overlay alpha blend mixer.
module positioned_overlay_alpha_blend_tb;
    import poab_pkg::*;

    // Run length guard: well above the slowest legal run (every beat paying the
    // longest sender gap and the longest receiver stall).
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    // Give loads, which yield no result, time to pass the pipeline and land.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned BURST_BEATS   = 300;
    localparam int          COORD_MAX     = 4095;

    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    positioned_overlay_alpha_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the configuration registers, updated on each accepted write.
    logic [CFG_DATA_W-1:0] frame_w  = 13'd1920;
    logic [CFG_DATA_W-1:0] frame_h  = 13'd1080;
    logic [CFG_DATA_W-1:0] win_left = '0;
    logic [CFG_DATA_W-1:0] win_top  = '0;
    logic [SIDE_W-1:0]     win_w    = '0;
    logic [SIDE_W-1:0]     win_h    = '0;

    // Overlay contents as the block should hold them (updated on accepted loads),
    // and which entries the stimulus has loaded so far (updated when queued).
    logic [WORD_W-1:0] overlay_shadow [OVL_DEPTH];
    bit                overlay_loaded [OVL_DEPTH];

    t_in_beat    beat_backlog [$];
    t_out_beat   blend_expect [$];
    t_out_beat   blend_want;
    int unsigned beats_queued   = 0;
    int unsigned beats_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;

    // Handshake shaping, set by the sequence below.
    bit          quiet_mode   = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned stall_run    = 0;
    int unsigned hold_left    = 0;

    function automatic int side_limit(input logic [SIDE_W-1:0] side);
        return (side > OVERLAY_MAX_SIDE) ? OVERLAY_MAX_SIDE : int'(side);
    endfunction

    // Test a frame position against the overlay window clipped to the frame;
    // return the offset into the overlay.
    function automatic bit window_hit(input int col, input int row,
                                      output int dx, output int dy);
        int left, top, ww, wh;
        left = int'($signed(win_left));
        top  = int'($signed(win_top));
        ww   = side_limit(win_w);
        wh   = side_limit(win_h);
        dx   = col - left;
        dy   = row - top;
        return ww > 0 && wh > 0 && col < int'(frame_w) && row < int'(frame_h) &&
               dx >= 0 && dx < ww && dy >= 0 && dy < wh;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] ovl,
                                                      input logic [CHAN_W-1:0] base,
                                                      input logic [CHAN_W-1:0] a);
        logic [31:0] acc;
        if (a == ALPHA_CLEAR) return base;
        if (a == ALPHA_OPAQUE) return ovl;
        acc = 32'(ovl) * 32'(a) + 32'(base) * (32'd255 - 32'(a)) + 32'd128;
        return acc[15:8];
    endfunction

    // Expected output for one base pixel, using the current shadow store.
    function automatic t_out_beat blend_predict(input t_in_beat px);
        t_out_beat         res;
        int                dx, dy;
        logic [WORD_W-1:0] word;
        res.out_blue  = px.blue;
        res.out_green = px.green;
        res.out_red   = px.red;
        res.out_alpha = px.alpha;
        res.covered   = 1'b0;
        if (window_hit(int'(px.pos_col), int'(px.pos_row), dx, dy)) begin
            word          = overlay_shadow[dy * OVERLAY_MAX_SIDE + dx];
            res.out_blue  = mix_channel(word[7:0],   px.blue,  word[31:24]);
            res.out_green = mix_channel(word[15:8],  px.green, word[31:24]);
            res.out_red   = mix_channel(word[23:16], px.red,   word[31:24]);
            res.covered   = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAN_W-1:0] rand_alpha();
        case ($urandom_range(0, 4))
            0: return ALPHA_CLEAR;
            1: return ALPHA_OPAQUE;
            default: return rand_chan();
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer beats from the backlog, predict on each accepted base pixel.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                beats_taken++;
                if (i_in_beat.kind == KIND_LOAD) begin
                    // Drop loads outside the overlay; they must not touch the store.
                    if (i_in_beat.pos_col < OVERLAY_MAX_SIDE &&
                        i_in_beat.pos_row < OVERLAY_MAX_SIDE) begin
                        overlay_shadow[int'(i_in_beat.pos_row) * OVERLAY_MAX_SIDE +
                                       int'(i_in_beat.pos_col)] =
                            {i_in_beat.alpha, i_in_beat.red, i_in_beat.green,
                             i_in_beat.blue};
                    end
                end else begin
                    blend_expect.push_back(blend_predict(i_in_beat));
                end
            end
            // Hold the beat while stalled; otherwise advance, idle or go quiet.
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (beat_backlog.size() > 0) begin
                    i_in_beat  <= beat_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left = quiet_mode ? 0 : pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each accepted result beat, shape the stall.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (blend_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d arrived with nothing expected: ", results_seen,
                                 "b=%02h g=%02h r=%02h a=%02h cov=%0b",
                                 o_out_beat.out_blue, o_out_beat.out_green,
                                 o_out_beat.out_red, o_out_beat.out_alpha,
                                 o_out_beat.covered);
                end else begin
                    blend_want = blend_expect.pop_front();
                    if (o_out_beat.out_blue  !== blend_want.out_blue  ||
                        o_out_beat.out_green !== blend_want.out_green ||
                        o_out_beat.out_red   !== blend_want.out_red   ||
                        o_out_beat.out_alpha !== blend_want.out_alpha ||
                        o_out_beat.covered   !== blend_want.covered) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("result %0d: ", results_seen,
                                     "expected b=%02h g=%02h r=%02h a=%02h cov=%0b, ",
                                     blend_want.out_blue, blend_want.out_green,
                                     blend_want.out_red, blend_want.out_alpha,
                                     blend_want.covered,
                                     "got b=%02h g=%02h r=%02h a=%02h cov=%0b",
                                     o_out_beat.out_blue, o_out_beat.out_green,
                                     o_out_beat.out_red, o_out_beat.out_alpha,
                                     o_out_beat.covered);
                    end
                end
            end
            // A long hold-off lets the pipeline fill and back up into the input.
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
            end else if (quiet_mode) begin
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        i_out_stall <= 1'b1;
                        stall_run = $urandom_range(8, 24);
                    end
                    2, 3, 4, 5, 6, 7, 8: begin
                        i_out_stall <= 1'b1;
                        stall_run = $urandom_range(0, 2);
                    end
                    default: begin
                        i_out_stall <= 1'b0;
                        stall_run = $urandom_range(0, 11);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:   frame_w  = value[CFG_DATA_W-1:0];
            CFG_FRAME_HEIGHT:  frame_h  = value[CFG_DATA_W-1:0];
            CFG_WINDOW_LEFT:   win_left = value[CFG_DATA_W-1:0];
            CFG_WINDOW_TOP:    win_top  = value[CFG_DATA_W-1:0];
            CFG_WINDOW_WIDTH:  win_w    = value[SIDE_W-1:0];
            CFG_WINDOW_HEIGHT: win_h    = value[SIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input int fw, input int fh, input int left, input int top,
                              input int ww, input int wh);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_WINDOW_LEFT, left);
        write_reg(CFG_WINDOW_TOP, top);
        write_reg(CFG_WINDOW_WIDTH, ww);
        write_reg(CFG_WINDOW_HEIGHT, wh);
    endtask

    // Pause the sequence until every beat is taken and every result is back.
    task automatic settle();
        while (beats_taken != beats_queued || blend_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_load(input int col, input int row,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] a);
        t_in_beat beat;
        beat.kind    = KIND_LOAD;
        beat.pos_col = col[POS_W-1:0];
        beat.pos_row = row[POS_W-1:0];
        beat.blue    = b;
        beat.green   = g;
        beat.red     = r;
        beat.alpha   = a;
        if (col < OVERLAY_MAX_SIDE && row < OVERLAY_MAX_SIDE)
            overlay_loaded[row * OVERLAY_MAX_SIDE + col] = 1'b1;
        beat_backlog.push_back(beat);
        beats_queued++;
    endtask

    // Queue a base pixel; load its overlay entry first if it was never written.
    task automatic queue_pixel(input int col, input int row,
                               input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] a);
        t_in_beat beat;
        int       dx, dy;
        if (window_hit(col, row, dx, dy) && !overlay_loaded[dy * OVERLAY_MAX_SIDE + dx])
            queue_load(dx, dy, rand_chan(), rand_chan(), rand_chan(), rand_alpha());
        beat.kind    = KIND_BASE;
        beat.pos_col = col[POS_W-1:0];
        beat.pos_row = row[POS_W-1:0];
        beat.blue    = b;
        beat.green   = g;
        beat.red     = r;
        beat.alpha   = a;
        beat_backlog.push_back(beat);
        beats_queued++;
    endtask

    // Random mix: mostly base pixels around the window, loads that refresh the
    // entries in use, and some noise across the whole coordinate range.
    // Every queued beat counts, preloads included.
    task automatic random_traffic(input int unsigned count);
        int          left, top, ww, wh, col, row;
        int unsigned made;
        int unsigned start;
        left  = int'($signed(win_left));
        top   = int'($signed(win_top));
        ww    = (side_limit(win_w) > 0) ? side_limit(win_w) : 1;
        wh    = (side_limit(win_h) > 0) ? side_limit(win_h) : 1;
        start = beats_queued;
        made  = 0;
        while (made < count) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    queue_load($urandom_range(0, ww - 1), $urandom_range(0, wh - 1),
                               rand_chan(), rand_chan(), rand_chan(), rand_alpha());
                end
                4: begin
                    // Mostly out of the overlay, so mostly dropped by the block.
                    col = $urandom_range(0, COORD_MAX);
                    row = $urandom_range(0, COORD_MAX);
                    queue_load(col, row, rand_chan(), rand_chan(), rand_chan(),
                               rand_alpha());
                end
                5, 6, 7: begin
                    col = ($urandom_range(0, 3) == 0) ? COORD_MAX * $urandom_range(0, 1)
                                                      : $urandom_range(0, COORD_MAX);
                    row = ($urandom_range(0, 3) == 0) ? COORD_MAX * $urandom_range(0, 1)
                                                      : $urandom_range(0, COORD_MAX);
                    queue_pixel(col, row, rand_chan(), rand_chan(), rand_chan(),
                                rand_chan());
                end
                default: begin
                    col = left + int'($urandom_range(0, ww + 7)) - 4;
                    row = top + int'($urandom_range(0, wh + 7)) - 4;
                    if (col < 0 || col > COORD_MAX) col = $urandom_range(0, COORD_MAX);
                    if (row < 0 || row > COORD_MAX) row = $urandom_range(0, COORD_MAX);
                    queue_pixel(col, row, rand_chan(), rand_chan(), rand_chan(),
                                rand_chan());
                end
            endcase
            made = beats_queued - start;
            // Now and then drain completely mid-phase.
            if ($urandom_range(0, 199) == 0) settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset config: window of zero size, nothing is blended. Loads out of
        // the overlay are dropped; writes past the register map are dropped.
        write_reg(CFG_UNMAPPED_LO, 13'h1FFF);
        write_reg(CFG_UNMAPPED_HI, 13'h0055);
        queue_load(0, 0, 8'h10, 8'h20, 8'h30, 8'd128);
        queue_load(OVERLAY_MAX_SIDE - 1, OVERLAY_MAX_SIDE - 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_load(OVERLAY_MAX_SIDE, 5, 8'hAA, 8'hAA, 8'hAA, ALPHA_OPAQUE);
        queue_load(5, COORD_MAX, 8'h55, 8'h55, 8'h55, ALPHA_OPAQUE);
        queue_pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_pixel(COORD_MAX, COORD_MAX, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        settle();

        // Negative origin, oversized sides saturating to the overlay limit.
        set_window(4096, 4096, -5, -3, 13'h1FFF, 200);
        queue_load(5, 3, 8'hFF, 8'h00, 8'hAA, ALPHA_CLEAR);
        queue_load(6, 3, 8'h12, 8'h34, 8'h56, ALPHA_OPAQUE);
        queue_load(7, 3, 8'hFF, 8'hFF, 8'hFF, 8'd128);
        queue_load(8, 3, 8'hFF, 8'h00, 8'h80, 8'd1);
        queue_load(9, 3, 8'h00, 8'hFF, 8'h7F, 8'd254);
        queue_pixel(0, 0, 8'h00, 8'hFF, 8'h55, 8'hFF);
        queue_pixel(1, 0, 8'hFF, 8'h00, 8'h01, 8'h00);
        queue_pixel(2, 0, 8'h00, 8'h00, 8'h00, 8'h80);
        queue_pixel(3, 0, 8'h00, 8'hFF, 8'hFF, 8'h7F);
        queue_pixel(4, 0, 8'hFF, 8'h00, 8'h00, 8'h01);
        queue_pixel(122, 0, 8'h11, 8'h22, 8'h33, 8'h44);   // last overlay column
        queue_pixel(123, 0, 8'h11, 8'h22, 8'h33, 8'h44);   // one past it
        queue_pixel(0, 124, 8'h55, 8'h66, 8'h77, 8'h88);   // last overlay row
        queue_pixel(0, 125, 8'h55, 8'h66, 8'h77, 8'h88);   // one past it
        settle();

        // Empty frame in either direction covers nothing.
        write_reg(CFG_FRAME_WIDTH, 0);
        queue_pixel(0, 0, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        settle();
        write_reg(CFG_FRAME_WIDTH, 4096);
        write_reg(CFG_FRAME_HEIGHT, 0);
        queue_pixel(1, 0, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        settle();

        // Random phases over a range of window settings.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: set_window(4096, 4096, 0, 0, OVERLAY_MAX_SIDE, OVERLAY_MAX_SIDE);
                1: set_window($urandom_range(1, 300), $urandom_range(1, 300),
                              int'($urandom_range(0, 440)) - 140,
                              int'($urandom_range(0, 440)) - 140,
                              $urandom_range(1, OVERLAY_MAX_SIDE),
                              $urandom_range(1, OVERLAY_MAX_SIDE));
                2: set_window(1, 1, 0, 0, 1, 1);
                3: set_window(13'h1FFF, 13'h1FFF, 13'h0FFF, 13'h0FFF, 255, 255);
                4: set_window(0, 4096, 13'h1000, 13'h1000, OVERLAY_MAX_SIDE, OVERLAY_MAX_SIDE);
                5: set_window($urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 8191), $urandom_range(0, 8191));
                6: set_window(640, 480, 600, 440, 0, 77);
                7: set_window(256, 256, 64, 64, OVERLAY_MAX_SIDE, OVERLAY_MAX_SIDE);
                default: set_window(1920, 1080, int'($urandom_range(0, 1964)) - 64,
                                    int'($urandom_range(0, 1104)) - 64,
                                    $urandom_range(1, OVERLAY_MAX_SIDE),
                                    $urandom_range(1, OVERLAY_MAX_SIDE));
            endcase
            quiet_mode = (phase == 2 || phase == 7);
            if (phase == 7) begin
                // Hold the receiver off while the sender streams back to back.
                hold_request = 1'b1;
                random_traffic(BURST_BEATS);
            end else begin
                random_traffic(175);
            end
            settle();
            quiet_mode = 1'b0;
        end

        settle();
        if (mismatch_count == 0 && blend_expect.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: end the run if it hangs.
    initial begin : watchdog
        int unsigned cycles_seen;
        cycles_seen = 0;
        while (cycles_seen < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_seen++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
